@@ hw/rtl/affa_pkg.sv @@
// Package: shared types and codes for the alternating first-fit allocator.
package affa_pkg;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_UNKNOWN  = 2'd2;

  // One result transaction from the engine to the output stage
  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] data_offset;
  } affa_result_t;

endpackage

@@ hw/rtl/affa_table.sv @@
// Block table memory: one synchronous read port, one write port.
module affa_table #(
  parameter int DEPTH = 256,
  parameter int DW    = 13
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata
);
  logic [DW-1:0] mem [DEPTH];

  // registered read, write-first not needed (engine interlocks)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ hw/rtl/affa_engine.sv @@
// Allocation engine: scans, splits, frees and merges over the block table.
module affa_engine #(
  parameter int ARENA_MAX_BYTES = 4096,
  parameter int HEADER_BYTES    = 24,
  parameter int MAX_BLOCKS      = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [12:0]           cfg_data,
  input  logic                  start,
  input  logic                  op,
  input  logic [11:0]           req,
  input  logic [11:0]           where,
  output logic                  busy,
  output logic                  done,
  output affa_pkg::affa_result_t result
);
  import affa_pkg::*;

  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int CW = AW + 1;
  localparam int OW = $clog2(ARENA_MAX_BYTES + 1) + 1;
  localparam logic [OW-1:0] HDR = OW'(HEADER_BYTES);

  // entry = {used, size}
  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_SCAN     = 11'b00000000010,
    S_SCANW    = 11'b00000000100,
    S_SHIFT    = 11'b00000001000,
    S_SHW      = 11'b00000010000,
    S_PUT      = 11'b00000100000,
    S_MRG      = 11'b00001000000,
    S_MRGW     = 11'b00010000000,
    S_DEL      = 11'b00100000000,
    S_DELW     = 11'b01000000000,
    S_DEL_STEP = 11'b10000000000
  } state_t;

  state_t          state;
  logic [CW-1:0]   count;
  logic            fwd;
  logic [OW-1:0]   arena;
  logic [CW-1:0]   idx;
  logic [OW-1:0]   off;
  logic [CW-1:0]   hit;
  logic [OW-1:0]   hit_off;
  logic [OW-1:0]   hit_size;
  logic            opr;
  logic [11:0]     reqr;
  logic [11:0]     wherer;
  logic [CW-1:0]   ptr;
  logic [AW-1:0]   raddr;
  logic [OW:0]     rdata;
  logic            we;
  logic [AW-1:0]   waddr;
  logic [OW:0]     wdata;
  logic [1:0]      mstep;
  logic            init_pend;
  logic [OW-1:0]   cfg_sat;

  affa_table #(.DEPTH(MAX_BLOCKS), .DW(OW + 1)) u_table (
    .clk(clk), .raddr(raddr), .rdata(rdata),
    .we(we), .waddr(waddr), .wdata(wdata)
  );

  logic         r_used;
  logic [OW-1:0] r_size;
  assign r_used = rdata[OW];
  assign r_size = rdata[OW-1:0];

  // saturate the arena register value
  always_comb begin
    cfg_sat = OW'(cfg_data);
    if (cfg_data > 13'(ARENA_MAX_BYTES)) cfg_sat = OW'(ARENA_MAX_BYTES);
    if (cfg_sat <= HDR) cfg_sat = HDR + OW'(1);
  end

  assign busy = (state != S_IDLE) || init_pend;
  assign raddr = ptr[AW-1:0];

  // sequencer
  always_ff @(posedge clk) begin
    done <= 1'b0;
    we   <= 1'b0;
    if (rst) begin
      state     <= S_IDLE;
      count     <= CW'(1);
      fwd       <= 1'b1;
      arena     <= OW'(ARENA_MAX_BYTES);
      init_pend <= 1'b1;
      ptr       <= '0;
    end else if (cfg_we) begin
      arena     <= cfg_sat;
      init_pend <= 1'b1;
      count     <= CW'(1);
    end else begin
      case (state)
        S_IDLE: begin
          if (init_pend) begin
            // only entry 0 is ever read below count
            we        <= 1'b1;
            waddr     <= '0;
            wdata     <= {1'b0, arena - HDR};
            init_pend <= 1'b0;
          end else if (start) begin
            opr    <= op;
            reqr   <= req;
            wherer <= where;
            off    <= HDR;
            hit    <= '0;
            if (op == OP_ALLOC && !fwd) begin
              idx <= count - CW'(1);
              ptr <= count - CW'(1);
            end else begin
              idx <= '0;
              ptr <= '0;
            end
            state <= S_SCANW;
          end
        end
        S_SCANW: state <= S_SCAN;
        S_SCAN: begin
          if (opr == OP_ALLOC && !r_used && r_size >= OW'(reqr)) begin
            hit      <= idx;
            hit_size <= r_size;
            // compute offset by forward walk to hit
            idx   <= '0;
            ptr   <= '0;
            off   <= HDR;
            if (idx == '0) begin
              hit_off <= HDR;
              mstep   <= 2'd0;
              state   <= S_PUT;
            end else begin
              state <= S_SHW;
              mstep <= 2'd1;
            end
          end else if (opr == OP_FREE && r_used && off == OW'(wherer)) begin
            hit      <= idx;
            hit_size <= r_size;
            state    <= S_PUT;
          end else begin
            off <= off + HDR + r_size;
            if (opr == OP_ALLOC && !fwd) begin
              if (idx == '0) begin
                fwd <= ~fwd;
                result <= '{status: ST_NO_SPACE, data_offset: '0};
                done <= 1'b1;
                state <= S_IDLE;
              end else begin
                idx <= idx - CW'(1);
                ptr <= idx - CW'(1);
                state <= S_SCANW;
              end
            end else if (idx + CW'(1) == count) begin
              if (opr == OP_ALLOC) begin
                fwd <= ~fwd;
                result <= '{status: ST_NO_SPACE, data_offset: '0};
              end else begin
                result <= '{status: ST_UNKNOWN, data_offset: '0};
              end
              done  <= 1'b1;
              state <= S_IDLE;
            end else begin
              idx <= idx + CW'(1);
              ptr <= idx + CW'(1);
              state <= S_SCANW;
            end
          end
        end
        S_SHW: begin
          // offset walk (mstep 1) or split shift read wait (mstep 2)
          state <= S_SHIFT;
        end
        S_SHIFT: begin
          if (mstep == 2'd1) begin
            off <= off + HDR + r_size;
            if (idx + CW'(1) == hit) begin
              hit_off <= off + HDR + r_size;
              state   <= S_PUT;
            end else begin
              idx <= idx + CW'(1);
              ptr <= idx + CW'(1);
              state <= S_SHW;
            end
          end else begin
            // move entry idx to idx+1, walking down
            we    <= 1'b1;
            waddr <= AW'(idx + CW'(1));
            wdata <= rdata;
            if (idx == hit + CW'(1)) begin
              state <= S_PUT;
              mstep <= 2'd3;
            end else begin
              idx <= idx - CW'(1);
              ptr <= idx - CW'(1);
              state <= S_SHW;
            end
          end
        end
        S_PUT: begin
          if (opr == OP_ALLOC) begin
            if (mstep != 2'd3 && hit_size > OW'(reqr) &&
                hit_size - OW'(reqr) >= HDR && count < CW'(MAX_BLOCKS)) begin
              if (hit + CW'(1) == count) begin
                mstep <= 2'd3;
              end else begin
                mstep <= 2'd2;
                idx   <= count - CW'(1);
                ptr   <= count - CW'(1);
                state <= S_SHW;
              end
            end else begin
              we    <= 1'b1;
              waddr <= AW'(hit);
              if (mstep == 2'd3) begin
                wdata <= {1'b1, OW'(reqr)};
                mstep <= 2'd0;
                state <= S_DEL;
              end else begin
                wdata <= {1'b1, hit_size};
                fwd   <= ~fwd;
                result <= '{status: ST_DONE, data_offset: hit_off[11:0]};
                done  <= 1'b1;
                state <= S_IDLE;
              end
            end
          end else begin
            // free: clear used, then look at the left neighbour (the right one if hit is entry 0)
            we    <= 1'b1;
            waddr <= AW'(hit);
            wdata <= {1'b0, hit_size};
            if (hit != '0) begin
              ptr   <= hit - CW'(1);
              state <= S_MRGW;
              mstep <= 2'd0;
            end else begin
              ptr   <= hit + CW'(1);
              state <= S_MRGW;
              mstep <= 2'd1;
            end
          end
        end
        S_DEL: begin
          // write new free leftover block after the split
          we    <= 1'b1;
          waddr <= AW'(hit + CW'(1));
          wdata <= {1'b0, hit_size - OW'(reqr) - HDR};
          count <= count + CW'(1);
          fwd   <= ~fwd;
          result <= '{status: ST_DONE, data_offset: hit_off[11:0]};
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_MRGW: state <= S_MRG;
        S_MRG: begin
          if (mstep == 2'd0) begin
            // left neighbour read
            if (!r_used && r_size != '0) begin
              hit       <= hit - CW'(1);
              hit_size  <= r_size + HDR + hit_size;
              idx       <= hit;
              we        <= 1'b1;
              waddr     <= AW'(hit - CW'(1));
              wdata     <= {1'b0, r_size + HDR + hit_size};
              mstep     <= 2'd2;
              ptr       <= hit + CW'(1);
              state     <= S_DELW;
            end else begin
              mstep <= 2'd1;
              ptr   <= hit + CW'(1);
              state <= S_MRGW;
            end
          end else begin
            // right neighbour read
            if (hit + CW'(1) < count && !r_used && hit_size != '0) begin
              we    <= 1'b1;
              waddr <= AW'(hit);
              wdata <= {1'b0, hit_size + HDR + r_size};
              hit_size <= hit_size + HDR + r_size;
              idx   <= hit + CW'(1);
              ptr   <= hit + CW'(2);
              mstep <= 2'd3;
              state <= S_DELW;
            end else begin
              result <= '{status: ST_DONE, data_offset: '0};
              done   <= 1'b1;
              state  <= S_IDLE;
            end
          end
        end
        S_DELW: state <= S_DEL_STEP;
        S_DEL_STEP: begin
          // remove entry idx by pulling entries down; ptr reads idx+1
          if (idx + CW'(1) >= count) begin
            count <= count - CW'(1);
            if (mstep == 2'd2) begin
              mstep <= 2'd1;
              ptr   <= hit + CW'(1);
              state <= S_MRGW;
            end else begin
              result <= '{status: ST_DONE, data_offset: '0};
              done   <= 1'b1;
              state  <= S_IDLE;
            end
          end else begin
            we    <= 1'b1;
            waddr <= AW'(idx);
            wdata <= rdata;
            idx   <= idx + CW'(1);
            ptr   <= idx + CW'(2);
            state <= S_DELW;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_nz: assert property (@(posedge clk) disable iff (rst) count != '0)
    else $error("block count zero");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_BLOCKS)) else $error("block count overflow");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE) else $error("done outside idle");
`endif
endmodule

@@ hw/rtl/alternating_first_fit_allocator.sv @@
// Top level: stream ports, output register and allocation engine.
//
// Usage: items enter on s_axis (tdata: operation, request_size, block_offset);
// results leave on m_axis (tdata: status, data_offset). One result per item.
// arena_size written through cfg_we/cfg_data reinitializes the block table to
// one free block; write only while idle.
// An allocate scans the table one entry at a time, then walks the table again
// to form the data offset and shifts entries up to split. A free scans to the
// block, then shifts entries down once per merge. The table memory with one
// read port and its registered read set the pace.
// One item is in work at a time; s_tready is low while the engine is busy,
// while a result is handed to the output register, or while it waits there.
// Reset clears the table to one free block of 4096 minus header bytes and
// sets the first scan to forward.
// When the receiver stalls, the result holds in the output register.
module alternating_first_fit_allocator #(
  parameter int ARENA_MAX_BYTES = 4096,
  parameter int HEADER_BYTES    = 24,
  parameter int MAX_BLOCKS      = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [12:0] cfg_data,       // arena_size
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,        // operation, request_size, block_offset
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata         // status, data_offset
);
  import affa_pkg::*;

  logic         busy;
  logic         done;
  logic         start;
  affa_result_t res;
  affa_result_t out_r;

  assign s_tready = !busy && !m_tvalid && !done;
  assign start    = s_tvalid && s_tready;

  affa_engine #(
    .ARENA_MAX_BYTES(ARENA_MAX_BYTES), .HEADER_BYTES(HEADER_BYTES),
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_engine (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .start(start), .op(s_tdata[0]), .req(s_tdata[12:1]), .where(s_tdata[24:13]),
    .busy(busy), .done(done), .result(res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done) begin
      m_tvalid <= 1'b1;
      out_r    <= res;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {2'b00, out_r.data_offset, out_r.status};

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> !s_tready) else $error("accept while busy");
  a_done_free: assert property (@(posedge clk) disable iff (rst)
    done |-> !m_tvalid) else $error("result overwrite");
  a_status_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_r.status != 2'd3) else $error("bad status");
`endif
endmodule

@@ tb/tb.sv @@
// Testbench for the alternating first-fit allocator: stream stimulus, self-checking predictor.
module tb;
  import affa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HDR       = 24;
  localparam int ARENA_MAX = 4096;
  localparam int NBLK      = 256;
  localparam int STALL_LIMIT = 20000;
  localparam int LONG_HOLD   = 3000;

  typedef enum {K_RAW, K_FREE_LIVE, K_ALLOC_TIGHT} item_kind_t;

  typedef struct {
    item_kind_t  kind;
    logic        op;
    logic [11:0] req;
    logic [11:0] where;
  } alloc_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [12:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // operation, request_size, block_offset
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // status, data_offset

  alternating_first_fit_allocator uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state: shadow copy of the block table
  int unsigned blk_size[NBLK];
  bit          blk_used[NBLK];
  int unsigned blk_count;
  bit          scan_fwd;
  int unsigned arena;

  alloc_req_t   pending_reqs[$];
  affa_result_t expected_results[$];
  alloc_req_t   cur_req;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_trig = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int mismatches = 0;
  int idle_cycles = 0;

  function automatic void table_clear();
    for (int i = 0; i < NBLK; i++) begin
      blk_size[i] = 0;
      blk_used[i] = 1'b0;
    end
    blk_size[0] = arena - HDR;
    blk_count = 1;
  endfunction

  function automatic void arena_write(int unsigned v);
    int unsigned a;
    a = v & 13'h1FFF;
    if (a > ARENA_MAX) a = ARENA_MAX;
    if (a <= HDR) a = HDR + 1;
    arena = a;
    table_clear();
  endfunction

  function automatic int unsigned offset_of(int unsigned idx);
    int unsigned off;
    off = 0;
    for (int j = 0; j < idx && j < blk_count; j++) off += HDR + blk_size[j];
    return off + HDR;
  endfunction

  function automatic void drop_entry(int unsigned idx);
    for (int j = idx; j + 1 < blk_count; j++) begin
      blk_size[j] = blk_size[j+1];
      blk_used[j] = blk_used[j+1];
    end
    blk_count--;
    blk_size[blk_count] = 0;
    blk_used[blk_count] = 1'b0;
  endfunction

  // Left absorbs right when both free and left is not zero-size
  function automatic bit coalesce(int unsigned left);
    if (left + 1 >= blk_count) return 1'b0;
    if (blk_used[left] || blk_used[left+1] || blk_size[left] == 0) return 1'b0;
    blk_size[left] += blk_size[left+1] + HDR;
    drop_entry(left + 1);
    return 1'b1;
  endfunction

  function automatic void claim_block(int unsigned idx, int unsigned req);
    int unsigned s;
    s = blk_size[idx];
    if (s > req && s - req >= HDR && blk_count < NBLK) begin
      for (int j = blk_count; j > idx + 1; j--) begin
        blk_size[j] = blk_size[j-1];
        blk_used[j] = blk_used[j-1];
      end
      blk_size[idx+1] = s - req - HDR;
      blk_used[idx+1] = 1'b0;
      blk_size[idx] = req;
      blk_count++;
    end
    blk_used[idx] = 1'b1;
  endfunction

  function automatic affa_result_t predict_result(alloc_req_t it);
    affa_result_t r;
    bit found;
    int unsigned hit, off;
    r.status = ST_DONE;
    r.data_offset = '0;
    found = 1'b0;
    hit = 0;
    if (it.op == OP_ALLOC) begin
      if (scan_fwd) begin
        for (int i = 0; i < blk_count && !found; i++)
          if (!blk_used[i] && blk_size[i] >= it.req) begin found = 1'b1; hit = i; end
      end else begin
        for (int i = blk_count; i > 0 && !found; i--)
          if (!blk_used[i-1] && blk_size[i-1] >= it.req) begin found = 1'b1; hit = i - 1; end
      end
      scan_fwd = !scan_fwd;
      if (found) begin
        claim_block(hit, it.req);
        off = offset_of(hit);
        r.data_offset = off[11:0];
      end else begin
        r.status = ST_NO_SPACE;
      end
    end else begin
      off = HDR;
      for (int i = 0; i < blk_count && !found; i++) begin
        if (blk_used[i] && off == it.where) begin found = 1'b1; hit = i; end
        off += HDR + blk_size[i];
      end
      if (found) begin
        blk_used[hit] = 1'b0;
        if (hit > 0 && coalesce(hit - 1)) hit--;
        void'(coalesce(hit));
      end else begin
        r.status = ST_UNKNOWN;
      end
    end
    return r;
  endfunction

  // Fill in operands that depend on the current table contents
  function automatic alloc_req_t bind_to_table(alloc_req_t it);
    int unsigned cand[$];
    int unsigned off, c;
    if (it.kind == K_FREE_LIVE) begin
      for (int i = 0; i < blk_count; i++) begin
        off = offset_of(i);
        if (blk_used[i] && off < 4096) cand.push_back(off);
      end
      if (cand.size() > 0) it.where = 12'(cand[$urandom_range(cand.size() - 1)]);
    end else if (it.kind == K_ALLOC_TIGHT) begin
      for (int i = 0; i < blk_count; i++)
        if (!blk_used[i] && blk_size[i] >= HDR) cand.push_back(blk_size[i]);
      if (cand.size() > 0) begin
        c = cand[$urandom_range(cand.size() - 1)];
        it.req = $urandom_range(1) ? 12'(c - HDR) : 12'(c);
      end
    end
    return it;
  endfunction

  // Driver: predict on each accepted transaction, then offer the next one
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) expected_results.push_back(predict_result(cur_req));
      if (!s_tvalid || s_tready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = bind_to_table(pending_reqs.pop_front());
          s_tdata <= {7'd0, cur_req.where, cur_req.req, cur_req.op};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver backpressure, with an occasional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_trig != hold_seen) begin
      hold_seen <= hold_trig;
      hold_left <= LONG_HOLD;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    affa_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result: tdata=%h", m_tdata);
      end else begin
        want = expected_results.pop_front();
        if (m_tdata[1:0] !== want.status || m_tdata[13:2] !== want.data_offset) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: status exp %0d got %0d, data_offset exp %0d got %0d",
                     want.status, m_tdata[1:0], want.data_offset, m_tdata[13:2]);
        end
      end
    end
  end

  // Watchdog on cycles without progress while work is outstanding
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (pending_reqs.size() == 0 && expected_results.size() == 0 && !s_tvalid)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_req(item_kind_t k, logic op, int unsigned rq, int unsigned wh);
    alloc_req_t it;
    it.kind = k;
    it.op = op;
    it.req = rq[11:0];
    it.where = wh[11:0];
    pending_reqs.push_back(it);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || s_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_arena(int unsigned v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v[12:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    arena_write(v);
  endtask

  task automatic queue_random(int n);
    int unsigned p;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(99);
      if (p < 35)      queue_req(K_RAW, OP_ALLOC, $urandom_range(200), $urandom);
      else if (p < 45) queue_req(K_ALLOC_TIGHT, OP_ALLOC, $urandom_range(50), $urandom);
      else if (p < 50) queue_req(K_RAW, OP_ALLOC, $urandom_range(4095), $urandom);
      else if (p < 90) queue_req(K_FREE_LIVE, OP_FREE, $urandom, $urandom_range(4095));
      else             queue_req(K_RAW, OP_FREE, $urandom, $urandom_range(4095));
    end
  endtask

  task automatic run_phase(int unsigned arena_val, int n, int s_idle, int r_stall, bit long_hold);
    write_arena(arena_val);
    send_idle_pct = s_idle;
    recv_stall_pct = r_stall;
    if (long_hold) hold_trig++;
    queue_random(n);
    wait_drained();
  endtask

  initial begin
    arena = ARENA_MAX;
    scan_fwd = 1'b1;
    table_clear();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Directed: field extremes, zero-size and tight-fit requests, unknown frees
    queue_req(K_RAW, OP_ALLOC, 0, 4095);
    queue_req(K_RAW, OP_ALLOC, 4095, 0);
    queue_req(K_RAW, OP_ALLOC, 100, 0);
    queue_req(K_RAW, OP_ALLOC, 4095, 4095);
    queue_req(K_RAW, OP_FREE, 4095, 0);
    queue_req(K_RAW, OP_FREE, 0, 4095);
    queue_req(K_RAW, OP_FREE, 0, 24);
    queue_req(K_RAW, OP_FREE, 0, 24);
    for (int i = 0; i < 5; i++) queue_req(K_ALLOC_TIGHT, OP_ALLOC, 0, 0);
    queue_req(K_RAW, OP_ALLOC, 0, 0);
    for (int i = 0; i < 6; i++) queue_req(K_FREE_LIVE, OP_FREE, 4095, 0);
    queue_req(K_RAW, OP_ALLOC, 4048, 0);
    queue_req(K_RAW, OP_ALLOC, 4072, 0);
    wait_drained();

    // Tiny and saturated arenas
    write_arena(24);
    queue_req(K_RAW, OP_ALLOC, 1, 0);
    queue_req(K_RAW, OP_ALLOC, 2, 0);
    queue_req(K_RAW, OP_FREE, 0, 24);
    wait_drained();
    write_arena(0);
    queue_req(K_RAW, OP_ALLOC, 0, 0);
    wait_drained();
    write_arena(8191);
    queue_req(K_RAW, OP_ALLOC, 4072, 0);
    wait_drained();

    // Random phases across arena settings and handshake pressure
    run_phase(4096, 300, 0, 0, 1'b0);
    run_phase(25, 150, 88, 0, 1'b0);
    run_phase(1000, 300, 0, 88, 1'b0);
    run_phase(4097, 300, 6, 6, 1'b0);
    run_phase(300, 250, 0, 0, 1'b1);
    run_phase(2047, 320, 0, 0, 1'b0);

    wait_drained();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
